### rtl/tlht_pkg.sv
package tlht_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int PRIME      = 17;

    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 32;

    localparam logic [FRAC_W-1:0] GOLDEN_MULT = 32'h9E37_79B9;

    localparam int CELLS   = TABLE_SIZE * TABLE_SIZE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
    localparam int TSZ_W   = $clog2(TABLE_SIZE + 1);
    localparam int ENTRY_W = KEY_W + VAL_W;

    // shared multiplier, remainders by reciprocal multiplication
    localparam int MUL_A_W  = KEY_W + 1;
    localparam int MUL_B_W  = KEY_W + 2;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int REM_W    = $clog2(PRIME);
    localparam int Q1_SHIFT = KEY_W + $clog2(PRIME);
    localparam int Q2_SHIFT = REM_W + $clog2(TABLE_SIZE);

    localparam logic [MUL_B_W-1:0] Q1_MULT =
        MUL_B_W'(((64'd1 << Q1_SHIFT) + 64'(PRIME - 1)) / 64'(PRIME));
    localparam logic [MUL_B_W-1:0] Q2_MULT =
        MUL_B_W'(((64'd1 << Q2_SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ROW_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_KEY,
        S_SUB_KEY,
        S_DIV_SLOT,
        S_SUB_SLOT,
        S_INS_HEAD,
        S_INS_PROBE,
        S_FIND
    } state_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [KEY_W-1:0]         primary_key;
        logic [KEY_W-1:0]         secondary_key;
        logic signed [VAL_W-1:0]  value_in;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  value_out;
    } rsp_t;

endpackage

### rtl/tlht_ram.sv
module tlht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/two_level_hash_table_core.sv
// channel   ports                  transfer when
// --------  ---------------------  ----------------------------------
// command   start, busy, request   start && !busy at rising clk
// result    done, response         done high, one cycle, no backpressure
//
// Per command: the accept cycle computes the key hash, then states S_DIV_KEY, S_SUB_KEY,
// S_DIV_SLOT and S_SUB_SLOT use the shared multiplier for (key2 mod PRIME) mod TABLE_SIZE,
// then the row probe: insert checks the valid flops, find does one RAM read per cycle
// (registered read). done is registered, and the core can already accept in the cycle
// that done is high. busy is high from accept until done.
// Reset clears all slot valid flags at once; no clearing pass.
module two_level_hash_table_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tlht_pkg::req_t    request,
    output logic              done,
    output tlht_pkg::rsp_t    response
);

    tlht_pkg::state_t state_reg, state_next;

    logic [tlht_pkg::CELLS-1:0]     valid_reg, valid_next;
    tlht_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [tlht_pkg::KEY_W-1:0]     pk_reg, pk_next;
    logic [tlht_pkg::KEY_W-1:0]     sk_reg, sk_next;
    logic [tlht_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [tlht_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [tlht_pkg::SLOT_W-1:0]    row_reg, row_next;
    logic [tlht_pkg::ADDR_W-1:0]    base_reg, base_next;
    logic [tlht_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [tlht_pkg::KEY_W-1:0]     quo_reg, quo_next;
    logic [tlht_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [tlht_pkg::CNT_W-1:0]     iss_reg, iss_next;
    logic [tlht_pkg::CNT_W-1:0]     chk_reg, chk_next;
    logic                           pend_reg, pend_next;
    logic                           vld_d_reg, vld_d_next;
    logic                           done_reg, done_next;
    tlht_pkg::rsp_t                 rsp_reg, rsp_next;

    logic [tlht_pkg::MUL_A_W-1:0]           mul_a;
    logic [tlht_pkg::MUL_B_W-1:0]           mul_b;
    logic [tlht_pkg::MUL_P_W-1:0]           mul_p;
    logic [tlht_pkg::FRAC_W+tlht_pkg::TSZ_W-1:0] row_prod;
    logic [tlht_pkg::ADDR_W-1:0]            probe_addr;
    logic [tlht_pkg::SLOT_W-1:0]            slot_inc;
    logic                                   slot_free;
    logic                                   find_issue;
    logic                                   find_hit;
    logic                                   find_miss;
    logic                                   ram_we;
    logic [tlht_pkg::ADDR_W-1:0]            ram_waddr;
    logic [tlht_pkg::ENTRY_W-1:0]           ram_wdata;
    logic [tlht_pkg::ENTRY_W-1:0]           ram_rdata;

    tlht_ram #(
        .WIDTH (tlht_pkg::ENTRY_W),
        .DEPTH (tlht_pkg::CELLS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (probe_addr),
        .rdata (ram_rdata)
    );

    // shared multiplier: key hash, then quotient and product for each remainder
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            tlht_pkg::S_IDLE:
            begin
                mul_a = tlht_pkg::MUL_A_W'(request.primary_key);
                mul_b = tlht_pkg::MUL_B_W'(tlht_pkg::GOLDEN_MULT);
            end
            tlht_pkg::S_DIV_KEY:
            begin
                mul_a = tlht_pkg::MUL_A_W'(sk_reg);
                mul_b = tlht_pkg::Q1_MULT;
            end
            tlht_pkg::S_SUB_KEY:
            begin
                mul_a = tlht_pkg::MUL_A_W'(quo_reg);
                mul_b = tlht_pkg::MUL_B_W'(tlht_pkg::PRIME);
            end
            tlht_pkg::S_DIV_SLOT:
            begin
                mul_a = tlht_pkg::MUL_A_W'(rem_reg);
                mul_b = tlht_pkg::Q2_MULT;
            end
            tlht_pkg::S_SUB_SLOT:
            begin
                mul_a = tlht_pkg::MUL_A_W'(quo_reg);
                mul_b = tlht_pkg::MUL_B_W'(tlht_pkg::TABLE_SIZE);
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p      = mul_a * mul_b;

    assign row_prod   = {{tlht_pkg::TSZ_W{1'b0}}, frac_reg}
                        * (tlht_pkg::FRAC_W + tlht_pkg::TSZ_W)'(tlht_pkg::TABLE_SIZE);
    assign probe_addr = base_reg + tlht_pkg::ADDR_W'(slot_reg);
    assign slot_inc   = (slot_reg == tlht_pkg::SLOT_W'(tlht_pkg::TABLE_SIZE - 1))
                        ? '0 : slot_reg + 1'b1;

    assign slot_free  = (state_reg == tlht_pkg::S_INS_HEAD) ? !valid_reg[base_reg]
                                                            : !valid_reg[probe_addr];
    assign find_issue = (iss_reg != tlht_pkg::CNT_W'(tlht_pkg::TABLE_SIZE));
    assign find_hit   = pend_reg && vld_d_reg
                        && (ram_rdata[tlht_pkg::ENTRY_W-1 -: tlht_pkg::KEY_W] == pk_reg);
    assign find_miss  = pend_reg && !find_hit
                        && (chk_reg == tlht_pkg::CNT_W'(tlht_pkg::TABLE_SIZE - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlht_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = tlht_pkg::S_DIV_KEY;
                end
            end
            tlht_pkg::S_DIV_KEY:
            begin
                state_next = tlht_pkg::S_SUB_KEY;
            end
            tlht_pkg::S_SUB_KEY:
            begin
                state_next = tlht_pkg::S_DIV_SLOT;
            end
            tlht_pkg::S_DIV_SLOT:
            begin
                state_next = tlht_pkg::S_SUB_SLOT;
            end
            tlht_pkg::S_SUB_SLOT:
            begin
                state_next = (cmd_reg == tlht_pkg::CMD_FIND) ? tlht_pkg::S_FIND
                                                             : tlht_pkg::S_INS_HEAD;
            end
            tlht_pkg::S_INS_HEAD:
            begin
                state_next = slot_free ? tlht_pkg::S_IDLE : tlht_pkg::S_INS_PROBE;
            end
            tlht_pkg::S_INS_PROBE:
            begin
                if (slot_free || iss_reg == tlht_pkg::CNT_W'(tlht_pkg::TABLE_SIZE - 1))
                begin
                    state_next = tlht_pkg::S_IDLE;
                end
            end
            tlht_pkg::S_FIND:
            begin
                if (find_hit || find_miss)
                begin
                    state_next = tlht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlht_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        pk_next    = pk_reg;
        sk_next    = sk_reg;
        val_next   = val_reg;
        frac_next  = frac_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        slot_next  = slot_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        iss_next   = iss_reg;
        chk_next   = chk_reg;
        pend_next  = 1'b0;
        vld_d_next = vld_d_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ram_we     = 1'b0;
        ram_waddr  = probe_addr;
        ram_wdata  = {pk_reg, val_reg};

        unique case (state_reg)
            tlht_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = request.cmd;
                    pk_next   = request.primary_key;
                    sk_next   = request.secondary_key;
                    val_next  = request.value_in;
                    frac_next = mul_p[tlht_pkg::FRAC_W-1:0];
                end
            end
            tlht_pkg::S_DIV_KEY:
            begin
                row_next = row_prod[tlht_pkg::FRAC_W +: tlht_pkg::SLOT_W];
                quo_next = tlht_pkg::KEY_W'(mul_p >> tlht_pkg::Q1_SHIFT);
            end
            tlht_pkg::S_SUB_KEY:
            begin
                base_next = tlht_pkg::ADDR_W'(row_reg * tlht_pkg::TABLE_SIZE);
                rem_next  = tlht_pkg::REM_W'(sk_reg - mul_p[tlht_pkg::KEY_W-1:0]);
            end
            tlht_pkg::S_DIV_SLOT:
            begin
                quo_next = tlht_pkg::KEY_W'(mul_p >> tlht_pkg::Q2_SHIFT);
            end
            tlht_pkg::S_SUB_SLOT:
            begin
                slot_next = tlht_pkg::SLOT_W'(rem_reg - mul_p[tlht_pkg::REM_W-1:0]);
                iss_next  = '0;
                chk_next  = '0;
            end
            tlht_pkg::S_INS_HEAD:
            begin
                ram_waddr = base_reg;
                if (slot_free)
                begin
                    ram_we              = 1'b1;
                    valid_next[base_reg] = 1'b1;
                    done_next           = 1'b1;
                    rsp_next.status     = tlht_pkg::ST_INSERTED;
                    rsp_next.value_out  = '0;
                end
            end
            tlht_pkg::S_INS_PROBE:
            begin
                if (slot_free)
                begin
                    ram_we                 = 1'b1;
                    valid_next[probe_addr] = 1'b1;
                    done_next              = 1'b1;
                    rsp_next.status        = tlht_pkg::ST_INSERTED;
                    rsp_next.value_out     = '0;
                end
                else if (iss_reg == tlht_pkg::CNT_W'(tlht_pkg::TABLE_SIZE - 1))
                begin
                    done_next          = 1'b1;
                    rsp_next.status    = tlht_pkg::ST_ROW_FULL;
                    rsp_next.value_out = '0;
                end
                else
                begin
                    slot_next = slot_inc;
                    iss_next  = iss_reg + 1'b1;
                end
            end
            tlht_pkg::S_FIND:
            begin
                // read issued this cycle is checked next cycle
                pend_next  = find_issue;
                vld_d_next = valid_reg[probe_addr];
                if (find_issue)
                begin
                    slot_next = slot_inc;
                    iss_next  = iss_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    chk_next = chk_reg + 1'b1;
                end
                if (find_hit)
                begin
                    pend_next          = 1'b0;
                    done_next          = 1'b1;
                    rsp_next.status    = tlht_pkg::ST_FOUND;
                    rsp_next.value_out = ram_rdata[tlht_pkg::VAL_W-1:0];
                end
                else if (find_miss)
                begin
                    pend_next          = 1'b0;
                    done_next          = 1'b1;
                    rsp_next.status    = tlht_pkg::ST_NOT_FOUND;
                    rsp_next.value_out = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlht_pkg::S_IDLE;
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        pk_reg    <= pk_next;
        sk_reg    <= sk_next;
        val_reg   <= val_next;
        frac_reg  <= frac_next;
        row_reg   <= row_next;
        base_reg  <= base_next;
        slot_reg  <= slot_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        iss_reg   <= iss_next;
        chk_reg   <= chk_next;
        vld_d_reg <= vld_d_next;
        rsp_reg   <= rsp_next;
    end

    assign busy     = (state_reg != tlht_pkg::S_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule
